// File: src/mbrc_pkg.sv
// package of types, constants and the crc function of the modbus rtu response checker
`default_nettype none

package mbrc_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  ExcBit   = 8'h80;
  localparam int unsigned MinLen   = 5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StShort = 3'd1,
    StCrc   = 3'd2,
    StExc   = 3'd3,
    StOvf   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_e    status;
    logic [7:0] exception_code;
    logic [8:0] frame_length;
    logic       error_sticky;
    logic       run_end;
  } out_t;

  // one byte of crc-16, lsb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/modbus_rtu_response_checker_top.sv
// top level of the modbus rtu response checker: frame state, crc and result queue
// results are registered in the result queue before they reach the output
// throughput: one byte per cycle; a byte can cause up to two results, which a
// four-entry result queue drains at one per cycle while out_ready_i is high, so
// in_ready_o drops only when fewer than two queue slots are free
// reset: rst_ni is asynchronous, active low, and clears frame state, sticky flag and queue
`default_nettype none

module modbus_rtu_response_checker_top #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire mbrc_pkg::in_t in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      mbrc_pkg::out_t out_data_o
);

  // count must hold MAX_FRAME + 1
  localparam int unsigned CntW = $clog2(MAX_FRAME + 2);

  // frame state
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      tail0_q, tail0_d;   // older of the two held-back bytes
  logic [7:0]      tail1_q, tail1_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      func_q, func_d;
  logic [7:0]      third_q, third_d;
  logic            err_q, err_d;

  // result queue
  mbrc_pkg::out_t                   queue_q [mbrc_pkg::QueueDepth];
  logic [mbrc_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mbrc_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mbrc_pkg::QueueCntW-1:0]   fill_q, fill_d;

  logic in_fire;
  logic out_fire;

  // per-transaction results
  logic            take;        // byte enters the delay line and crc
  logic [CntW-1:0] cnt_new;
  logic [15:0]     crc_new;
  logic [7:0]      tail0_new, tail1_new, func_new, third_new;
  logic            pay_vld;
  logic            stat_vld;
  logic            err_new;
  logic [31:0]     cnt_ext;
  mbrc_pkg::status_e status;
  logic [7:0]      exc_code;
  mbrc_pkg::out_t  pay_res, stat_res;
  mbrc_pkg::out_t  push0, push1;
  logic [1:0]      push_n;

  // room for two results is always required, so a byte never has to wait half-done
  assign in_ready_o  = (fill_q <= mbrc_pkg::QueueCntW'(mbrc_pkg::QueueDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (fill_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_comb begin
    take      = (cnt_q < CntW'(MAX_FRAME));
    cnt_new   = take ? (cnt_q + CntW'(1)) : CntW'(MAX_FRAME + 1);
    crc_new   = crc_q;
    tail0_new = tail0_q;
    tail1_new = tail1_q;
    func_new  = func_q;
    third_new = third_q;
    pay_vld   = 1'b0;
    if (take) begin
      // the byte leaving the delay line is frame byte cnt_new - 2
      if (cnt_new >= CntW'(3)) begin
        crc_new = mbrc_pkg::crc_byte(crc_q, tail0_q);
        pay_vld = (cnt_new >= CntW'(mbrc_pkg::MinLen));
      end
      if (cnt_new == CntW'(2)) begin
        func_new = in_data_i.rx_byte;
      end
      if (cnt_new == CntW'(3)) begin
        third_new = in_data_i.rx_byte;
      end
      tail0_new = tail1_q;
      tail1_new = in_data_i.rx_byte;
    end

    stat_vld = in_data_i.last_byte;
    err_new  = err_q;
    exc_code = 8'h00;
    // checks in order of precedence
    priority if (cnt_new > CntW'(MAX_FRAME)) begin
      status = mbrc_pkg::StOvf;
    end else if (cnt_new < CntW'(mbrc_pkg::MinLen)) begin
      status = mbrc_pkg::StShort;
    end else if ({tail1_new, tail0_new} != crc_new) begin
      status = mbrc_pkg::StCrc;
    end else if ((func_new & mbrc_pkg::ExcBit) != 8'h00) begin
      status   = mbrc_pkg::StExc;
      exc_code = third_new;
      err_new  = stat_vld ? 1'b1 : err_q;
    end else begin
      status = mbrc_pkg::StOk;
    end

    cnt_ext = 32'(cnt_new);

    // payload result carries the sticky flag from before this byte
    pay_res.kind           = mbrc_pkg::KindPayload;
    pay_res.payload_byte   = tail0_q;
    pay_res.status         = mbrc_pkg::StOk;
    pay_res.exception_code = 8'h00;
    pay_res.frame_length   = cnt_ext[8:0];
    pay_res.error_sticky   = err_q;
    pay_res.run_end        = 1'b0;

    stat_res.kind           = mbrc_pkg::KindStatus;
    stat_res.payload_byte   = 8'h00;
    stat_res.status         = status;
    stat_res.exception_code = exc_code;
    stat_res.frame_length   = cnt_ext[8:0];
    stat_res.error_sticky   = err_new;
    stat_res.run_end        = 1'b1;

    // payload goes ahead of the status
    push0  = pay_vld ? pay_res : stat_res;
    push1  = stat_res;
    push_n = in_fire ? ({1'b0, pay_vld} + {1'b0, stat_vld}) : 2'd0;

    // next frame state
    crc_d   = crc_q;
    tail0_d = tail0_q;
    tail1_d = tail1_q;
    cnt_d   = cnt_q;
    func_d  = func_q;
    third_d = third_q;
    err_d   = err_q;
    if (in_fire) begin
      err_d = err_new;
      if (stat_vld) begin
        // frame done, back to the reset values
        crc_d   = mbrc_pkg::CrcInit;
        tail0_d = 8'h00;
        tail1_d = 8'h00;
        cnt_d   = '0;
        func_d  = 8'h00;
        third_d = 8'h00;
      end else begin
        crc_d   = crc_new;
        tail0_d = tail0_new;
        tail1_d = tail1_new;
        cnt_d   = cnt_new;
        func_d  = func_new;
        third_d = third_new;
      end
    end

    // queue pointers
    wr_ptr_d = wr_ptr_q + mbrc_pkg::QueuePtrW'(push_n);
    rd_ptr_d = out_fire ? (rd_ptr_q + mbrc_pkg::QueuePtrW'(1)) : rd_ptr_q;
    fill_d   = fill_q + mbrc_pkg::QueueCntW'(push_n)
             - mbrc_pkg::QueueCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= mbrc_pkg::CrcInit;
      tail0_q  <= 8'h00;
      tail1_q  <= 8'h00;
      cnt_q    <= '0;
      func_q   <= 8'h00;
      third_q  <= 8'h00;
      err_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      crc_q    <= crc_d;
      tail0_q  <= tail0_d;
      tail1_q  <= tail1_d;
      cnt_q    <= cnt_d;
      func_q   <= func_d;
      third_q  <= third_d;
      err_q    <= err_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage, data only (payload and status results), no reset
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + mbrc_pkg::QueuePtrW'(1)] <= push1;
    end
  end

endmodule

`default_nettype wire

// File: src/mbrc_checker.sv
// port-level assertions for the modbus rtu response checker and their bind
`default_nettype none

module mbrc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire mbrc_pkg::out_t out_data_o
);

  logic seen_err_q;

  // remembers that a delivered result showed the sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_err_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && out_data_o.error_sticky) begin
      seen_err_q <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // run_end marks status results and only those
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.run_end == (out_data_o.kind == mbrc_pkg::KindStatus)))
    else $error("run_end does not match kind");

  // payload results carry no status and no exception code
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == mbrc_pkg::KindPayload) |->
      (out_data_o.status == mbrc_pkg::StOk) && (out_data_o.exception_code == 8'h00))
    else $error("payload result with status fields");

  // an exception status always shows the sticky flag
  a_exc_sets_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == mbrc_pkg::StExc) |-> out_data_o.error_sticky)
    else $error("exception without sticky flag");

  // the sticky flag never clears once shown
  a_sticky_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_err_q |-> out_data_o.error_sticky)
    else $error("sticky flag cleared");

endmodule

bind modbus_rtu_response_checker_top mbrc_checker u_mbrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench of the modbus rtu response checker: frames, crc, status and payload
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_FRAME    = 256;
  localparam int unsigned TOTAL_BYTES  = 1650;
  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  mbrc_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  mbrc_pkg::out_t out_data_o;

  modbus_rtu_response_checker_top #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the frame state, updated on every accepted input transaction
  logic [15:0] crc_acc     = mbrc_pkg::CrcInit;
  logic [7:0]  tail_q [2]  = '{8'h00, 8'h00};  // [0] is the older byte
  int unsigned frame_count = 0;
  logic [7:0]  func_byte   = 8'h00;
  logic [7:0]  third_b     = 8'h00;
  logic        sticky_flag = 1'b0;

  mbrc_pkg::out_t expected_results [$];
  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;

  // idling controls, switched by the tests
  bit          in_gaps_on    = 1'b1;
  bit          out_stalls_on = 1'b1;
  int unsigned stall_left    = 0;

  // crc-16 over one byte, fed one data bit per shift
  function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ data[k]) begin
        r = (r >> 1) ^ mbrc_pkg::CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // works out the results that one accepted byte causes
  task automatic model_byte(input mbrc_pkg::in_t item);
    mbrc_pkg::out_t    r;
    logic [7:0]        leaving;
    mbrc_pkg::status_e st;
    logic [7:0]        code;
    if (frame_count < MAX_FRAME) begin
      frame_count++;
      if (frame_count >= 3) begin
        // the byte leaving the delay line is not crc, so it feeds the crc
        leaving = tail_q[0];
        crc_acc = crc16_update(crc_acc, leaving);
        if (frame_count >= mbrc_pkg::MinLen) begin
          r              = '0;
          r.kind         = mbrc_pkg::KindPayload;
          r.payload_byte = leaving;
          r.status       = mbrc_pkg::StOk;
          r.frame_length = frame_count[8:0];
          r.error_sticky = sticky_flag;
          expected_results = {expected_results, r};
        end
      end
      if (frame_count == 2) begin
        func_byte = item.rx_byte;
      end
      if (frame_count == 3) begin
        third_b = item.rx_byte;
      end
      tail_q[0] = tail_q[1];
      tail_q[1] = item.rx_byte;
    end else begin
      // past the frame limit: count saturates, byte is dropped
      frame_count = MAX_FRAME + 1;
    end

    if (item.last_byte) begin
      code = 8'h00;
      if (frame_count > MAX_FRAME) begin
        st = mbrc_pkg::StOvf;
      end else if (frame_count < mbrc_pkg::MinLen) begin
        st = mbrc_pkg::StShort;
      end else if ({tail_q[1], tail_q[0]} != crc_acc) begin
        st = mbrc_pkg::StCrc;
      end else if ((func_byte & mbrc_pkg::ExcBit) != 8'h00) begin
        st          = mbrc_pkg::StExc;
        code        = third_b;
        sticky_flag = 1'b1;
      end else begin
        st = mbrc_pkg::StOk;
      end
      r                = '0;
      r.kind           = mbrc_pkg::KindStatus;
      r.status         = st;
      r.exception_code = code;
      r.frame_length   = frame_count[8:0];
      r.error_sticky   = sticky_flag;
      r.run_end        = 1'b1;
      expected_results = {expected_results, r};
      // frame state returns to reset, the sticky flag stays
      crc_acc     = mbrc_pkg::CrcInit;
      tail_q[0]   = 8'h00;
      tail_q[1]   = 8'h00;
      frame_count = 0;
      func_byte   = 8'h00;
      third_b     = 8'h00;
    end
  endtask

  task automatic check_result(input mbrc_pkg::out_t act);
    mbrc_pkg::out_t exp;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] unexpected result: kind=%0d payload=%02h status=%0d len=%0d",
                 $time, act.kind, act.payload_byte, act.status, act.frame_length);
      end
    end else begin
      exp = expected_results.pop_front();
      if (act.kind !== exp.kind || act.payload_byte !== exp.payload_byte ||
          act.status !== exp.status || act.exception_code !== exp.exception_code ||
          act.frame_length !== exp.frame_length || act.error_sticky !== exp.error_sticky ||
          act.run_end !== exp.run_end) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] exp: kind=%0d pay=%02h st=%0d exc=%02h len=%0d stk=%0d end=%0d",
                   $time, exp.kind, exp.payload_byte, exp.status, exp.exception_code,
                   exp.frame_length, exp.error_sticky, exp.run_end);
          $display("[%0t] act: kind=%0d pay=%02h st=%0d exc=%02h len=%0d stk=%0d end=%0d",
                   $time, act.kind, act.payload_byte, act.status, act.exception_code,
                   act.frame_length, act.error_sticky, act.run_end);
        end
      end
    end
  endtask

  // both channels are observed at the rising edge; the input is modeled first,
  // since its results can never show up in the same cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        model_byte(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
      end
    end
  end

  // receiver: random stall bursts while enabled
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input transaction; valid stays high into the next call unless a gap is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.rx_byte   <= b;
    in_data_i.last_byte <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame [$]);
    foreach (frame[i]) begin
      send_byte(frame[i], i == frame.size() - 1);
    end
  endtask

  // node, function, data, then the crc low byte first
  function automatic void append_crc(ref logic [7:0] frame [$]);
    logic [15:0] c;
    c = mbrc_pkg::CrcInit;
    foreach (frame[i]) begin
      c = crc16_update(c, frame[i]);
    end
    frame = {frame, c[7:0], c[15:8]};
  endfunction

  function automatic void build_good(ref logic [7:0] frame [$], input logic [7:0] node,
                                     input logic [7:0] fn, input int unsigned data_len);
    frame = {node, fn};
    repeat (data_len) frame = {frame, 8'($urandom)};
    append_crc(frame);
  endfunction

  function automatic void build_noise(ref logic [7:0] frame [$], input int unsigned len);
    frame = {};
    repeat (len) frame = {frame, 8'($urandom)};
  endfunction

  // frames that end before the crc could be there
  task automatic test_short_frames();
    logic [7:0] frame [$];
    build_noise(frame, 1);
    send_frame(frame);
    frame = '{8'h11, 8'h83, 8'h02};  // exception function, still too short
    send_frame(frame);
    build_noise(frame, 4);
    send_frame(frame);
  endtask

  // shortest well-formed frame with byte extremes, then a corrupted crc
  task automatic test_good_and_bad_crc();
    logic [7:0] frame [$];
    frame = '{8'h00, 8'h7F, 8'hFF};
    append_crc(frame);
    send_frame(frame);
    frame = '{8'hFF, 8'h03, 8'h00};
    append_crc(frame);
    frame[4] = frame[4] ^ 8'h80;
    send_frame(frame);
  endtask

  // exception response sets the sticky flag and reports the exception code
  task automatic test_exception_response();
    logic [7:0] frame [$];
    frame = '{8'h01, 8'h83, 8'h02};
    append_crc(frame);
    send_frame(frame);
    frame = '{8'h01, 8'h03, 8'h01};  // a later ok frame keeps the flag
    append_crc(frame);
    send_frame(frame);
  endtask

  // sender holds off mid-frame until the block has delivered everything
  task automatic test_drain_pause();
    logic [7:0] frame [$];
    build_good(frame, 8'h05, 8'h04, 8);
    for (int i = 0; i < 8; i++) begin
      send_byte(frame[i], 1'b0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    for (int i = 8; i < frame.size(); i++) begin
      send_byte(frame[i], i == frame.size() - 1);
    end
  endtask

  // frame exactly at the limit, then frames running past it
  task automatic test_frame_limits();
    logic [7:0] frame [$];
    build_good(frame, 8'h07, 8'h10, MAX_FRAME - 4);
    send_frame(frame);
    build_good(frame, 8'h07, 8'h10, MAX_FRAME - 3);
    send_frame(frame);
    build_noise(frame, MAX_FRAME + 4);
    send_frame(frame);
  endtask

  // mostly well-formed frames with random content, the rest corrupted or noise
  task automatic test_random_frames(input int unsigned byte_goal, input bit with_idle);
    logic [7:0]  frame [$];
    int unsigned pick;
    int unsigned pos;
    logic [7:0]  fn;
    while (bytes_sent < byte_goal) begin
      // stretches with and without idling
      in_gaps_on    = with_idle && ($urandom_range(0, 3) != 0);
      out_stalls_on = with_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      fn   = 8'($urandom);
      if (pick <= 5) begin
        if ($urandom_range(0, 3) != 0) begin
          fn[7] = 1'b0;
        end
        build_good(frame, 8'($urandom), fn,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16));
      end else if (pick == 6) begin
        build_good(frame, 8'($urandom), fn, $urandom_range(0, 16));
        pos = $urandom_range(0, frame.size() - 1);
        frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick == 7) begin
        build_noise(frame, $urandom_range(1, 4));
      end else if (pick == 8) begin
        build_noise(frame, $urandom_range(5, 20));
      end else begin
        fn[7] = 1'b1;
        build_good(frame, 8'($urandom), fn, 1);
      end
      send_frame(frame);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_frames();
    test_good_and_bad_crc();
    test_exception_response();
    test_drain_pause();
    test_frame_limits();
    test_random_frames(RANDOM_BYTES, 1'b1);
    // closing part runs at full rate on both sides
    test_random_frames(TOTAL_BYTES, 1'b0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mbrc_pkg.sv
src/modbus_rtu_response_checker_top.sv
src/mbrc_checker.sv
verif/testbench.sv
